@@ design/point_in_region_test_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the point in region test
// Shared concurrent property forms, clocked on the rising edge and muted in
// reset.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_REGION_TEST_ASSERT_SVH
`define POINT_IN_REGION_TEST_ASSERT_SVH

// Hold cond at every edge outside reset.
`define PIR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Require cons in the same cycle as ante.
`define PIR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Require cons in the cycle after ante.
`define PIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/pir_pkg.sv @@
// ----------------------------------------------------------------------------
// Point in region test package
// Sizes and shared types of the vertex ring and the edge evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pir_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int COORD_W      = 32;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	// Region command carried in tuser.
	typedef enum logic [1:0] {
		OP_SET_BOX    = 2'd0,
		OP_ADD_VERTEX = 2'd1,
		OP_ADD_Z      = 2'd2,
		OP_QUERY      = 2'd3
	} op_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	// One polygon edge handed to the evaluator.
	typedef struct packed {
		logic    valid;
		vertex_t a;
		vertex_t b;
	} edge_req_t;

	typedef struct packed {
		logic busy;
		logic parity;
	} edge_stat_t;

endpackage

`default_nettype wire

@@ design/point_in_region_test.sv @@
// ----------------------------------------------------------------------------
// Point in region test
// Box or XY polygon region with bounds; queries count ray crossings over a
// rotating ring of vertex cells.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                                  | tuser
//  ---------+-----------+----------------------------------------+---------
//  s_*      | in        | x, x_high, y, y_high, z, z_high (6x32) | op [1:0]
//  m_*      | out       | inside_res [0], vertex_dropped [1]      | -
//
//  Set box, add vertex, add z range and any query that needs no ring scan
//  leave their beat in the output register on the next cycle.
//  A polygon query inside the bounds turns the vertex ring once, then drains
//  the edge pipe and loads the output register.
//  Reset is asynchronous; it clears mode, bounds and vertex count but not the
//  vertex cells, which are read only below the count.
//  A new beat is taken only when idle and the output register is free or
//  being emptied; a stalled output beat holds the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_in_region_test_assert.svh"

module point_in_region_test
	import pir_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // coord_x, coord_x_high, coord_y, coord_y_high,
	                                // coord_z, coord_z_high (32 bits each, low first)
	input  logic [1:0]   s_tuser,   // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata    // inside_res, vertex_dropped, zero fill
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_VERTICES);

	state_t state_q;

	logic             polygon_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] step_q;
	coord_t           min_x_q, min_y_q, min_z_q;
	coord_t           max_x_q, max_y_q, max_z_q;
	coord_t           px_q, py_q;
	vertex_t          first_q, prev_q;

	logic out_valid_q, out_inside_q, out_drop_q;

	op_t    op;
	coord_t in_x, in_xh, in_y, in_yh, in_z, in_zh;
	logic   accept, out_free, in_bounds, has_room;
	logic   scan_start, shift_en, append;
	coord_t z_lo, z_hi;

	vertex_t    cell_val [MAX_VERTICES];
	vertex_t    new_vertex;
	edge_req_t  edge_req;
	edge_stat_t edge_stat;

	// Unpack the input beat.
	assign op    = op_t'(s_tuser);
	assign in_x  = s_tdata[31:0];
	assign in_xh = s_tdata[63:32];
	assign in_y  = s_tdata[95:64];
	assign in_yh = s_tdata[127:96];
	assign in_z  = s_tdata[159:128];
	assign in_zh = s_tdata[191:160];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign in_bounds = in_x >= min_x_q && in_x <= max_x_q &&
	                   in_y >= min_y_q && in_y <= max_y_q &&
	                   in_z >= min_z_q && in_z <= max_z_q;

	assign has_room   = count_q < FULL;
	assign append     = accept && op == OP_ADD_VERTEX && has_room;
	assign scan_start = accept && op == OP_QUERY && polygon_q && in_bounds;

	// Turn the ring once per scanned query, ending where it started.
	assign shift_en = (state_q == ST_SCAN) && step_q < FULL;

	assign new_vertex.x = in_x;
	assign new_vertex.y = in_y;

	// Z range: widen by both values.
	always_comb begin
		z_lo = min_z_q;
		z_hi = max_z_q;
		if (in_z < z_lo) begin
			z_lo = in_z;
		end
		if (in_zh < z_lo) begin
			z_lo = in_zh;
		end
		if (in_z > z_hi) begin
			z_hi = in_z;
		end
		if (in_zh > z_hi) begin
			z_hi = in_zh;
		end
	end

	// Ring of vertex cells; cell 0 feeds the edge evaluator.
	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		localparam int NEXT = (i + 1) % MAX_VERTICES;
		pir_cell u_cell (
			.clk      (clk),
			.load_en  (append && count_q == CNT_W'(i)),
			.load_val (new_vertex),
			.shift_en (shift_en),
			.shift_in (cell_val[NEXT]),
			.val      (cell_val[i])
		);
	end

	// Edge n runs from vertex n-1 to vertex n; the last step closes the polygon.
	always_comb begin
		edge_req.valid = (state_q == ST_SCAN) && step_q != '0 && step_q <= count_q;
		edge_req.a     = prev_q;
		edge_req.b     = (step_q == count_q) ? first_q : cell_val[0];
	end

	pir_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.px     (px_q),
		.py     (py_q),
		.clear  (scan_start),
		.req    (edge_req),
		.stat   (edge_stat)
	);

	// Region state and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			polygon_q <= 1'b0;
			count_q   <= '0;
			step_q    <= '0;
			min_x_q   <= {1'b0, {(COORD_W-1){1'b1}}};
			min_y_q   <= {1'b0, {(COORD_W-1){1'b1}}};
			min_z_q   <= {1'b0, {(COORD_W-1){1'b1}}};
			max_x_q   <= {1'b1, {(COORD_W-1){1'b0}}};
			max_y_q   <= {1'b1, {(COORD_W-1){1'b0}}};
			max_z_q   <= {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_SET_BOX: begin
								polygon_q <= 1'b0;
								min_x_q   <= in_x;
								max_x_q   <= in_xh;
								min_y_q   <= in_y;
								max_y_q   <= in_yh;
								min_z_q   <= in_z;
								max_z_q   <= in_zh;
							end
							OP_ADD_VERTEX: begin
								polygon_q <= 1'b1;
								if (has_room) begin
									count_q <= count_q + 1'b1;
								end
								if (in_x < min_x_q) begin
									min_x_q <= in_x;
								end
								if (in_x > max_x_q) begin
									max_x_q <= in_x;
								end
								if (in_y < min_y_q) begin
									min_y_q <= in_y;
								end
								if (in_y > max_y_q) begin
									max_y_q <= in_y;
								end
								if (in_z < min_z_q) begin
									min_z_q <= in_z;
								end
								if (in_z > max_z_q) begin
									max_z_q <= in_z;
								end
							end
							OP_ADD_Z: begin
								min_z_q <= z_lo;
								max_z_q <= z_hi;
							end
							default: begin
								if (scan_start) begin
									step_q  <= '0;
									state_q <= ST_SCAN;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					step_q <= step_q + 1'b1;
					if (step_q == FULL) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!edge_stat.busy && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query point and the running edge endpoints.
	always_ff @(posedge clk) begin
		if (scan_start) begin
			px_q <= in_x;
			py_q <= in_y;
		end
		if (state_q == ST_SCAN) begin
			prev_q <= cell_val[0];
			if (step_q == '0) begin
				first_q <= cell_val[0];
			end
		end
	end

	// Output register: one beat per input beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !scan_start) begin
			out_valid_q <= 1'b1;
		end else if (state_q == ST_DRAIN && !edge_stat.busy && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !scan_start) begin
			out_inside_q <= (op == OP_QUERY) && !polygon_q && in_bounds;
			out_drop_q   <= (op == OP_ADD_VERTEX) && !has_room;
		end else if (state_q == ST_DRAIN && !edge_stat.busy && out_free) begin
			out_inside_q <= edge_stat.parity;
			out_drop_q   <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_drop_q, out_inside_q};

	`PIR_ASSERT_ALWAYS(a_count_cap, clk, arst_n, count_q <= FULL, "vertex count past capacity")
	`PIR_ASSERT_IMPLIES(a_edge_range, clk, arst_n, edge_req.valid,
		step_q != '0 && step_q <= count_q, "edge issued outside stored vertices")
	`PIR_ASSERT_IMPLIES(a_idle_quiet, clk, arst_n, state_q == ST_IDLE,
		!edge_stat.busy, "edge pipe busy while idle")

endmodule

`default_nettype wire

@@ design/pir_cell.sv @@
// ----------------------------------------------------------------------------
// Vertex cell
// Holds one stored vertex; loads on append, passes it to its neighbor when
// the ring turns.
// ----------------------------------------------------------------------------
`default_nettype none

module pir_cell
	import pir_pkg::*;
(
	input  logic    clk,
	input  logic    load_en,
	input  vertex_t load_val,
	input  logic    shift_en,
	input  vertex_t shift_in,
	output vertex_t val
);

	vertex_t val_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			val_q <= load_val;
		end else if (shift_en) begin
			val_q <= shift_in;
		end
	end

	assign val = val_q;

endmodule

`default_nettype wire

@@ design/pir_edge.sv @@
// ----------------------------------------------------------------------------
// Edge crossing evaluator
// Three-stage pipe: classify the edge, multiply the cross terms, compare and
// fold the crossing into the parity.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_in_region_test_assert.svh"

module pir_edge
	import pir_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  coord_t     px,
	input  coord_t     py,
	input  logic       clear,
	input  edge_req_t  req,
	output edge_stat_t stat
);

	typedef enum logic [1:0] {
		EDGE_MISS = 2'd0,
		EDGE_HIT  = 2'd1,
		EDGE_MUL  = 2'd2
	} edge_kind_t;

	logic    v_s1, v_s2, v_s3;
	vertex_t a_s1, b_s1;

	edge_kind_t               kind_c, kind_s2, kind_s3;
	logic signed [DIFF_W-1:0] d1_c, d2_c, d3_c, d4_c;
	logic signed [DIFF_W-1:0] d1_s2, d2_s2, d3_s2, d4_s2;
	logic signed [PROD_W-1:0] p1_s3, p2_s3;
	logic                     hit_c;
	logic                     parity_q;

	// Stage 1: latch the edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			a_s1 <= req.a;
			b_s1 <= req.b;
		end
	end

	// Order the endpoints by y and settle the easy cases.
	always_comb begin
		vertex_t hv, lv;
		if (a_s1.y > b_s1.y) begin
			hv = a_s1;
			lv = b_s1;
		end else begin
			hv = b_s1;
			lv = a_s1;
		end
		d1_c = DIFF_W'(py) - DIFF_W'(hv.y);
		d2_c = DIFF_W'(lv.x) - DIFF_W'(hv.x);
		d3_c = DIFF_W'(px) - DIFF_W'(hv.x);
		d4_c = DIFF_W'(lv.y) - DIFF_W'(hv.y);
		if (a_s1.y == b_s1.y) begin
			kind_c = EDGE_MISS;
		end else if ((hv.y > py && lv.y > py) || (hv.y < py && lv.y < py)) begin
			kind_c = EDGE_MISS;
		end else if (hv.x < px && lv.x < px) begin
			kind_c = EDGE_MISS;
		end else if (hv.x >= px && lv.x >= px) begin
			kind_c = EDGE_HIT;
		end else begin
			kind_c = EDGE_MUL;
		end
	end

	// Stage 2: differences; stage 3: products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			kind_s2 <= kind_c;
			d1_s2   <= d1_c;
			d2_s2   <= d2_c;
			d3_s2   <= d3_c;
			d4_s2   <= d4_c;
		end
		if (v_s2) begin
			kind_s3 <= kind_s2;
			p1_s3   <= PROD_W'(d1_s2) * PROD_W'(d2_s2);
			p2_s3   <= PROD_W'(d3_s2) * PROD_W'(d4_s2);
		end
	end

	// Crossing lies at or right of the point when p1 <= p2.
	always_comb begin
		case (kind_s3)
			EDGE_HIT: hit_c = 1'b1;
			EDGE_MUL: hit_c = (p1_s3 <= p2_s3);
			default:  hit_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (clear) begin
			parity_q <= 1'b0;
		end else if (v_s3) begin
			parity_q <= parity_q ^ hit_c;
		end
	end

	assign stat.busy   = v_s1 | v_s2 | v_s3;
	assign stat.parity = parity_q;

	`PIR_ASSERT_NEXT(a_s1_to_s2, clk, arst_n, v_s1, v_s2, "edge lost between s1 and s2")
	`PIR_ASSERT_NEXT(a_s2_to_s3, clk, arst_n, v_s2, v_s3, "edge lost between s2 and s3")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Point in region test bench
// Drives region commands (set box, add vertex, add z range, query point) as
// stream beats and checks every output beat against a bit-exact model of the
// box and ray-crossing polygon tests kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
	import pir_pkg::*;
();

	// Receiver stall styles; the receiver switches between them at random.
	typedef enum int {
		RX_ALWAYS   = 0,
		RX_COIN     = 1,
		RX_SPARSE   = 2,
		RX_PERIODIC = 3
	} rx_mode_t;

	typedef struct packed {
		op_t    op;
		coord_t x;
		coord_t x_hi;
		coord_t y;
		coord_t y_hi;
		coord_t z;
		coord_t z_hi;
	} region_cmd_t;

	// Same layout as m_tdata, lowest bit last.
	typedef struct packed {
		logic [5:0] pad;
		logic       dropped;
		logic       in_region;
	} region_answer_t;

	localparam coord_t COORD_MAX    = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN    = {1'b1, {(COORD_W-1){1'b0}}};
	localparam int     STALL_LIMIT  = 4000;
	localparam int     DRAIN_CYCLES = MAX_VERTICES + 16;
	localparam int     RANDOM_STOP  = 610;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata  = '0;   // coord_x, coord_x_high, coord_y, coord_y_high,
	                               // coord_z, coord_z_high (32 bits each, low first)
	logic [1:0]   s_tuser  = OP_SET_BOX;   // op
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;         // inside_res, vertex_dropped, zero fill

	point_in_region_test dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Region model: mode, bounds and vertex ring, updated once per
	// accepted input beat. Values are the post-reset state.
	// ------------------------------------------------------------------
	bit     poly_mode    = 1'b0;
	coord_t lo_x         = COORD_MAX;
	coord_t lo_y         = COORD_MAX;
	coord_t lo_z         = COORD_MAX;
	coord_t hi_x         = COORD_MIN;
	coord_t hi_y         = COORD_MIN;
	coord_t hi_z         = COORD_MIN;
	coord_t vert_x [MAX_VERTICES];
	coord_t vert_y [MAX_VERTICES];
	int     vertex_total = 0;

	region_answer_t answer_queue [$];
	int             mismatch_count = 0;
	int             beat_index     = 0;
	int             items_sent     = 0;
	int             burst_left     = 0;

	function automatic void widen_range(input coord_t v, inout coord_t lo, inout coord_t hi);
		if (hi < v)
			hi = v;
		if (lo > v)
			lo = v;
	endfunction

	// Does the edge a-b cross the half-line from p towards +x? Horizontal
	// edges never count. The crossing position is compared exactly by
	// cross-multiplying the 33-bit differences into 66-bit products.
	function automatic bit edge_crosses(coord_t px, coord_t py, coord_t ax, coord_t ay,
			coord_t bx, coord_t by);
		coord_t                   hx, hy, lx, ly;
		logic signed [DIFF_W-1:0] d_py, d_lx, d_px, d_ly;
		logic signed [PROD_W-1:0] lhs, rhs;
		if (ay == by)
			return 1'b0;
		if (ay > by) begin
			hx = ax; hy = ay; lx = bx; ly = by;
		end else begin
			hx = bx; hy = by; lx = ax; ly = ay;
		end
		if ((hy > py && ly > py) || (hy < py && ly < py))
			return 1'b0;
		if (hx < px && lx < px)
			return 1'b0;
		if (hx >= px && lx >= px)
			return 1'b1;
		d_py = py - hy;
		d_lx = lx - hx;
		d_px = px - hx;
		d_ly = ly - hy;
		lhs  = d_py * d_lx;
		rhs  = d_px * d_ly;
		return lhs <= rhs;
	endfunction

	// Apply one command to the region model and return the beat it owes.
	function automatic region_answer_t predict_region_answer(region_cmd_t c);
		region_answer_t r;
		bit             in_box;
		int             crossings;
		int             nxt;
		r = '0;
		case (c.op)
			OP_SET_BOX: begin
				poly_mode = 1'b0;
				lo_x = c.x; hi_x = c.x_hi;
				lo_y = c.y; hi_y = c.y_hi;
				lo_z = c.z; hi_z = c.z_hi;
			end
			OP_ADD_VERTEX: begin
				poly_mode = 1'b1;
				if (vertex_total < MAX_VERTICES) begin
					vert_x[vertex_total] = c.x;
					vert_y[vertex_total] = c.y;
					vertex_total++;
				end else begin
					r.dropped = 1'b1;
				end
				widen_range(c.x, lo_x, hi_x);
				widen_range(c.y, lo_y, hi_y);
				widen_range(c.z, lo_z, hi_z);
			end
			OP_ADD_Z: begin
				widen_range(c.z, lo_z, hi_z);
				widen_range(c.z_hi, lo_z, hi_z);
			end
			default: begin
				in_box = c.x >= lo_x && c.x <= hi_x && c.y >= lo_y && c.y <= hi_y &&
					c.z >= lo_z && c.z <= hi_z;
				if (!poly_mode) begin
					r.in_region = in_box;
				end else if (in_box) begin
					crossings = 0;
					for (int n = 0; n < vertex_total; n++) begin
						nxt = (n + 1 < vertex_total) ? n + 1 : 0;
						if (edge_crosses(c.x, c.y, vert_x[n], vert_y[n], vert_x[nxt], vert_y[nxt]))
							crossings++;
					end
					r.in_region = crossings[0];
				end
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of random length with random gaps between them.
	// Valid is only dropped when a real gap follows, so it never gets two
	// updates in one step.
	// ------------------------------------------------------------------
	task automatic send_op(op_t op, coord_t x, coord_t xh, coord_t y, coord_t yh,
			coord_t z, coord_t zh);
		region_cmd_t    c;
		region_answer_t owed;
		int             gap;
		c.op = op;
		c.x = x; c.x_hi = xh;
		c.y = y; c.y_hi = yh;
		c.z = z; c.z_hi = zh;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= c.op;
		s_tdata  <= {c.z_hi, c.z, c.y_hi, c.y, c.x_hi, c.x};
		do
			@(posedge clk);
		while (!s_tready);
		// The beat went in at this edge: advance the model in acceptance order.
		owed         = predict_region_answer(c);
		answer_queue = {answer_queue, owed};
		items_sent++;
	endtask

	function automatic coord_t rnd_coord();
		return coord_t'($urandom);
	endfunction

	// Small coordinates around the origin, where polygons get dense.
	function automatic coord_t near_coord();
		return coord_t'($urandom_range(0, 2400)) - 1200;
	endfunction

	function automatic coord_t vertex_coord();
		return ($urandom_range(0, 11) == 0) ? rnd_coord() : near_coord();
	endfunction

	function automatic coord_t pick_between(coord_t lo, coord_t hi);
		logic [COORD_W-1:0] span;
		if (hi < lo)
			return rnd_coord();
		span = hi - lo;
		return lo + coord_t'($urandom_range(span, 0));
	endfunction

	// Mostly inside [lo, hi], now and then on a bound or one step past it.
	function automatic coord_t pick_axis(coord_t lo, coord_t hi);
		case ($urandom_range(0, 15))
			0: return lo;
			1: return hi;
			2: return lo - 1;
			3: return hi + 1;
			default: return pick_between(lo, hi);
		endcase
	endfunction

	function automatic void box_axis(output coord_t lo, output coord_t hi);
		coord_t t;
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				lo = near_coord();
				hi = lo + coord_t'($urandom_range(0, 600));
				if ($urandom_range(0, 7) == 0) begin
					t = lo; lo = hi; hi = t;
				end
			end
			3: begin
				lo = COORD_MIN;
				hi = COORD_MAX;
			end
			default: begin
				lo = rnd_coord();
				hi = rnd_coord();
			end
		endcase
	endfunction

	task automatic random_query();
		coord_t x, y, z;
		int     k, idx;
		x = pick_axis(lo_x, hi_x);
		y = pick_axis(lo_y, hi_y);
		z = ($urandom_range(0, 7) == 0) ? pick_axis(lo_z, hi_z) : pick_between(lo_z, hi_z);
		k = $urandom_range(0, 9);
		if (k < 3 && vertex_total > 0) begin
			// Land on a vertex row or column to hit horizontal edges and ties.
			idx = $urandom_range(0, vertex_total - 1);
			if (k == 0 || $urandom_range(0, 1))
				x = vert_x[idx];
			if (k == 0 || $urandom_range(0, 1))
				y = vert_y[idx];
		end else if (k == 3) begin
			x = near_coord();
			y = near_coord();
		end else if (k == 4) begin
			x = rnd_coord();
			y = rnd_coord();
			z = rnd_coord();
		end
		send_op(OP_QUERY, x, rnd_coord(), y, rnd_coord(), z, rnd_coord());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset bounds are inverted, so a box query answers 0; a z range
	// widens only the z bounds.
	task automatic test_reset_state();
		send_op(OP_QUERY, 0, rnd_coord(), 0, rnd_coord(), 0, rnd_coord());
		send_op(OP_ADD_Z, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), COORD_MIN, COORD_MAX);
	endtask

	// Inclusive box test at the extremes and on the faces, z widening in box
	// mode, and a fully inverted box.
	task automatic test_box_bounds();
		send_op(OP_SET_BOX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
		send_op(OP_QUERY, COORD_MIN, rnd_coord(), COORD_MIN, rnd_coord(), COORD_MIN, rnd_coord());
		send_op(OP_QUERY, COORD_MAX, rnd_coord(), COORD_MAX, rnd_coord(), COORD_MAX, rnd_coord());
		send_op(OP_SET_BOX, -10, 10, -20, 20, 0, 5);
		send_op(OP_QUERY, 10, rnd_coord(), -20, rnd_coord(), 5, rnd_coord());
		send_op(OP_QUERY, 11, rnd_coord(), 0, rnd_coord(), 0, rnd_coord());
		send_op(OP_QUERY, 0, rnd_coord(), 0, rnd_coord(), -1, rnd_coord());
		send_op(OP_ADD_Z, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 3, -1);
		send_op(OP_QUERY, 0, rnd_coord(), 0, rnd_coord(), -1, rnd_coord());
		send_op(OP_SET_BOX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
		send_op(OP_QUERY, 0, rnd_coord(), 0, rnd_coord(), 0, rnd_coord());
	endtask

	// Bounds start inverted, so they collapse onto the new vertices. Walk a
	// single vertex, a triangle with a horizontal base, and one far vertex
	// that pushes the products to full width.
	task automatic test_polygon_shapes();
		send_op(OP_ADD_VERTEX, 0, rnd_coord(), 0, rnd_coord(), 0, rnd_coord());
		send_op(OP_QUERY, 0, rnd_coord(), 0, rnd_coord(), 0, rnd_coord());
		send_op(OP_ADD_VERTEX, 100, rnd_coord(), 0, rnd_coord(), 0, rnd_coord());
		send_op(OP_ADD_VERTEX, 0, rnd_coord(), 100, rnd_coord(), 10, rnd_coord());
		send_op(OP_QUERY, 10, rnd_coord(), 10, rnd_coord(), 5, rnd_coord());
		send_op(OP_QUERY, 0, rnd_coord(), 0, rnd_coord(), 0, rnd_coord());
		send_op(OP_QUERY, 50, rnd_coord(), 50, rnd_coord(), 0, rnd_coord());
		send_op(OP_QUERY, 10, rnd_coord(), 10, rnd_coord(), 11, rnd_coord());
		send_op(OP_QUERY, -1, rnd_coord(), 10, rnd_coord(), 0, rnd_coord());
		send_op(OP_ADD_VERTEX, COORD_MIN, rnd_coord(), COORD_MAX, rnd_coord(), COORD_MIN,
			rnd_coord());
		send_op(OP_QUERY, -1000000, rnd_coord(), 1000000, rnd_coord(), 0, rnd_coord());
		send_op(OP_QUERY, 99, rnd_coord(), 1, rnd_coord(), 0, rnd_coord());
	endtask

	// Phases of box work and polygon growth, each followed by a run of
	// queries aimed at the current bounds and stored vertices.
	task automatic test_random_regions();
		coord_t xl, xh, yl, yh, zl, zh;
		while (items_sent < RANDOM_STOP) begin
			if ($urandom_range(0, 9) < 3) begin
				box_axis(xl, xh);
				box_axis(yl, yh);
				box_axis(zl, zh);
				send_op(OP_SET_BOX, xl, xh, yl, yh, zl, zh);
				if ($urandom_range(0, 3) == 0)
					send_op(OP_ADD_Z, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
						vertex_coord(), vertex_coord());
				repeat ($urandom_range(6, 16)) random_query();
			end else begin
				if ($urandom_range(0, 1))
					send_op(OP_SET_BOX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
						COORD_MAX, COORD_MIN);
				repeat ($urandom_range(1, 4))
					send_op(OP_ADD_VERTEX, vertex_coord(), rnd_coord(), vertex_coord(),
						rnd_coord(), vertex_coord(), rnd_coord());
				if ($urandom_range(0, 3) == 0)
					send_op(OP_ADD_Z, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
						near_coord(), near_coord());
				repeat ($urandom_range(8, 20)) random_query();
			end
		end
	endtask

	// Fill the store, push a few vertices past it (dropped, bounds still
	// widen), then set a box and add again: the old ring must still be used.
	task automatic test_full_store();
		int adds;
		adds = MAX_VERTICES - vertex_total + 3;
		repeat (adds) begin
			send_op(OP_ADD_VERTEX, vertex_coord(), rnd_coord(), vertex_coord(), rnd_coord(),
				vertex_coord(), rnd_coord());
			random_query();
		end
		send_op(OP_SET_BOX, -500, 500, -500, 500, -500, 500);
		random_query();
		send_op(OP_ADD_VERTEX, near_coord(), rnd_coord(), near_coord(), rnd_coord(),
			near_coord(), rnd_coord());
		repeat (6) random_query();
	endtask

	// ------------------------------------------------------------------
	// Receiver: stall style changes at random, including stretches where it
	// never stalls.
	// ------------------------------------------------------------------
	rx_mode_t    rx_mode    = RX_ALWAYS;
	int          rx_left    = 0;
	logic [15:0] rx_phase   = '0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
			rx_left = $urandom_range(40, 300);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			RX_ALWAYS:   m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
			default:     m_tready <= (rx_phase[2:0] != 3'd0);
		endcase
	end

	// ------------------------------------------------------------------
	// Result check: compare every output beat with the oldest expectation.
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("beat %0d: %s expected %0h, got %0h", beat_index, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		region_answer_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (answer_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("beat %0d: output %0h with no command pending", beat_index, m_tdata);
			end else begin
				want = answer_queue.pop_front();
				check_field("inside_res", 8'(want.in_region), 8'(got.in_region));
				check_field("vertex_dropped", 8'(want.dropped), 8'(got.dropped));
				check_field("zero fill", 8'(want.pad), 8'(got.pad));
			end
			beat_index++;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run when no beat moves on either side for too long.
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("** point_in_region_test: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// Hold reset, then release it on an edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_box_bounds();
		test_polygon_shapes();
		test_random_regions();
		test_full_store();

		s_tvalid <= 1'b0;
		// Wait for every owed beat, then give a late or extra beat time to show.
		while (answer_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("** point_in_region_test: PASSED **");
		else
			$display("** point_in_region_test: FAILED **");
		$finish;
	end

endmodule
